// ----- hw/rtl/unary_class_output_decoder_top_assert.svh -----
// Assertion macros for the unary class output decoder checker.
// Needs a clock and an active-low reset name at each use.
`ifndef UNARY_CLASS_OUTPUT_DECODER_TOP_ASSERT_SVH
`define UNARY_CLASS_OUTPUT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define UCOD_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UCOD_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ucod_pkg.sv -----
// Shared types, widths, codes and saturation helpers of the unary class output decoder.
// No dependencies.
package ucod_pkg;

    localparam int CNT_W   = 9;   // element count, rows up to 511 elements
    localparam int POS_W   = 10;  // signed position, -1 .. 510
    localparam int SCORE_W = 32;
    localparam int DIFF_W  = 33;
    localparam int SUM_W   = 48;
    localparam int BIN_W   = 16;
    localparam int LIMIT_W = 31;
    localparam int MODE_W  = 3;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 32;
    localparam int MUL_A_W = 33;
    localparam int PROD_W  = 50;
    localparam int SCL_W   = 66;

    localparam logic [MODE_W-1:0] MODE_REGR    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ARGMAX  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UNARY   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MAXCONF = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MEAN    = 3'd4;

    localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_LIMIT = 2'd1;
    localparam logic [IDX_W-1:0] REG_BIN   = 2'd2;

    localparam logic [SCORE_W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [SCORE_W-1:0] NO_CONF = 32'hFFFF_0000;
    localparam logic [SCORE_W-1:0] HEUR_DEAD = 32'hFFFF_FFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 31'd32768;

    // Control from the sequencer to the row tracker.
    typedef struct packed {
        logic take;
        logic clear;
    } row_ctl_t;

    // Running row status; signed quantities are stored as plain vectors.
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [SCORE_W-1:0] last;
        logic [SCORE_W-1:0] first;
        logic [SCORE_W-1:0] arg_val;
        logic [POS_W-1:0]   arg_pos;
        logic [DIFF_W-1:0]  best_val;
        logic [POS_W-1:0]   best_pos;
        logic               hit;
        logic [POS_W-1:0]   hit_pos;
        logic [DIFF_W-1:0]  hit_conf;
        logic [DIFF_W-1:0]  mac_c;
        logic [CNT_W-1:0]   mac_k;
    } row_stat_t;

    function automatic logic [SCORE_W-1:0] sat_diff(input logic [DIFF_W-1:0] v);
        logic [SCORE_W-1:0] r;
        if (v[DIFF_W-1] == v[DIFF_W-2])
            r = v[SCORE_W-1:0];
        else if (v[DIFF_W-1])
            r = 32'h8000_0000;
        else
            r = 32'h7FFF_FFFF;
        return r;
    endfunction

    function automatic logic [SCORE_W-1:0] sat_wide(input logic [SCL_W-1:0] v);
        logic [SCORE_W-1:0] r;
        if ($signed(v) > $signed({{(SCL_W-SCORE_W+1){1'b0}}, {(SCORE_W-1){1'b1}}}))
            r = 32'h7FFF_FFFF;
        else if ($signed(v) < $signed({{(SCL_W-SCORE_W+1){1'b1}}, {(SCORE_W-1){1'b0}}}))
            r = 32'h8000_0000;
        else
            r = v[SCORE_W-1:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/ucod_row_track.sv -----
// Per-element row tracking: argmax, best unary confidence, threshold hit, MAC operands.
// Depends on ucod_pkg.
module ucod_row_track #(
    parameter int MAX_CLASSES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ucod_pkg::row_ctl_t               ctl,
    input  logic [ucod_pkg::SCORE_W-1:0]     score,
    input  logic [ucod_pkg::LIMIT_W-1:0]     limit,
    output ucod_pkg::row_stat_t              stat
);

    logic [ucod_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [ucod_pkg::SCORE_W-1:0] prev_reg, prev_next;
    logic [ucod_pkg::SCORE_W-1:0] first_reg, first_next;
    logic [ucod_pkg::SCORE_W-1:0] arg_val_reg, arg_val_next;
    logic [ucod_pkg::POS_W-1:0]   arg_pos_reg, arg_pos_next;
    logic [ucod_pkg::DIFF_W-1:0]  best_val_reg, best_val_next;
    logic [ucod_pkg::POS_W-1:0]   best_pos_reg, best_pos_next;
    logic                         hit_reg, hit_next;
    logic [ucod_pkg::POS_W-1:0]   hit_pos_reg, hit_pos_next;
    logic [ucod_pkg::DIFF_W-1:0]  hit_conf_reg, hit_conf_next;
    logic [ucod_pkg::DIFF_W-1:0]  mac_c_reg, mac_c_next;
    logic [ucod_pkg::CNT_W-1:0]   mac_k_reg, mac_k_next;

    logic [ucod_pkg::DIFF_W-1:0]  diff;
    logic [ucod_pkg::POS_W-1:0]   pos_prev;

    // c = previous - current, 33-bit signed
    assign diff = {prev_reg[ucod_pkg::SCORE_W-1], prev_reg}
                - {score[ucod_pkg::SCORE_W-1], score};
    assign pos_prev = {1'b0, count_reg} - {{(ucod_pkg::POS_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        count_next    = count_reg;
        prev_next     = prev_reg;
        first_next    = first_reg;
        arg_val_next  = arg_val_reg;
        arg_pos_next  = arg_pos_reg;
        best_val_next = best_val_reg;
        best_pos_next = best_pos_reg;
        hit_next      = hit_reg;
        hit_pos_next  = hit_pos_reg;
        hit_conf_next = hit_conf_reg;
        mac_c_next    = mac_c_reg;
        mac_k_next    = mac_k_reg;
        if (ctl.clear)
        begin
            count_next    = '0;
            prev_next     = ucod_pkg::ONE_Q16;
            first_next    = '0;
            arg_val_next  = '0;
            arg_pos_next  = '0;
            best_val_next = '0;
            best_pos_next = '1;
            hit_next      = 1'b0;
            hit_pos_next  = '0;
            hit_conf_next = '0;
            mac_k_next    = '0;
        end
        else if (ctl.take)
        begin
            mac_c_next = diff;
            mac_k_next = '0;
            if (count_reg < ucod_pkg::CNT_W'(MAX_CLASSES))
            begin
                if (count_reg == '0)
                begin
                    first_next    = score;
                    arg_val_next  = score;
                    arg_pos_next  = '0;
                    best_val_next = diff;
                    best_pos_next = '1;
                end
                else
                begin
                    if ($signed(score) > $signed(arg_val_reg))
                    begin
                        arg_val_next = score;
                        arg_pos_next = {1'b0, count_reg};
                    end
                    if ($signed(diff) > $signed(best_val_reg))
                    begin
                        best_val_next = diff;
                        best_pos_next = pos_prev;
                    end
                    mac_k_next = pos_prev[ucod_pkg::CNT_W-1:0];
                end
                if (!hit_reg && ($signed({score[ucod_pkg::SCORE_W-1], score})
                                 < $signed({2'b00, limit})))
                begin
                    hit_next      = 1'b1;
                    hit_pos_next  = pos_prev;
                    hit_conf_next = diff;
                end
                prev_next  = score;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            prev_reg     <= ucod_pkg::ONE_Q16;
            first_reg    <= '0;
            arg_val_reg  <= '0;
            arg_pos_reg  <= '0;
            best_val_reg <= '0;
            best_pos_reg <= '1;
            hit_reg      <= 1'b0;
            hit_pos_reg  <= '0;
            hit_conf_reg <= '0;
            mac_k_reg    <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            prev_reg     <= prev_next;
            first_reg    <= first_next;
            arg_val_reg  <= arg_val_next;
            arg_pos_reg  <= arg_pos_next;
            best_val_reg <= best_val_next;
            best_pos_reg <= best_pos_next;
            hit_reg      <= hit_next;
            hit_pos_reg  <= hit_pos_next;
            hit_conf_reg <= hit_conf_next;
            mac_k_reg    <= mac_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_c_reg <= mac_c_next;
    end

    assign stat = '{count:    count_reg,
                    last:     prev_reg,
                    first:    first_reg,
                    arg_val:  arg_val_reg,
                    arg_pos:  arg_pos_reg,
                    best_val: best_val_reg,
                    best_pos: best_pos_reg,
                    hit:      hit_reg,
                    hit_pos:  hit_pos_reg,
                    hit_conf: hit_conf_reg,
                    mac_c:    mac_c_reg,
                    mac_k:    mac_k_reg};

endmodule

// ----- hw/rtl/ucod_mult.sv -----
// Shared 33 x 16 signed-by-unsigned multiplier with a registered product.
// Depends on ucod_pkg.
module ucod_mult (
    input  logic                          clk,
    input  logic                          en,
    input  logic [ucod_pkg::MUL_A_W-1:0]  a,
    input  logic [ucod_pkg::BIN_W-1:0]    b,
    output logic [ucod_pkg::PROD_W-1:0]   prod
);

    logic signed [ucod_pkg::MUL_A_W-1:0] a_s;
    logic signed [ucod_pkg::BIN_W:0]     b_s;
    logic signed [ucod_pkg::PROD_W-1:0]  prod_next;
    logic        [ucod_pkg::PROD_W-1:0]  prod_reg;

    assign a_s       = $signed(a);
    assign b_s       = $signed({1'b0, b});
    assign prod_next = a_s * b_s;

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- hw/rtl/unary_class_output_decoder_top.sv -----
// Unary class output decoder: one Q16.16 score per transfer, one result per row.
// Per score: accept in IDLE, then one pass through the shared multiplier in MAC; input stalls.
// Row end: MAC, NL, then SCALE, or in mean mode WAIT, LO, HI, ADD and RND, which run two extra
// multiplier passes to scale the 48-bit weighted sum by the bin width; OUT registers the result.
// Reset (rst_n, async, active low): mode argmax, threshold 0.5, bin width 1, row state cleared.
// Depends on ucod_pkg, ucod_row_track, ucod_mult.
module unary_class_output_decoder_top #(
    parameter int MAX_CLASSES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // score input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ucod_pkg::SCORE_W-1:0]  score,
    input  logic                          row_end,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ucod_pkg::SCORE_W-1:0]  heuristic,
    output logic [ucod_pkg::SCORE_W-1:0]  confidence,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ucod_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ucod_pkg::DATA_W-1:0]   cfg_data
);

    // Sequencer states. One element walks IDLE -> MAC -> IDLE. A row end continues
    // with NL (final operand pick) and then either SCALE or the mean path
    // WAIT -> LO -> HI -> ADD -> RND, and finally OUT.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAC   = 4'd1;
    localparam logic [3:0] S_NL    = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_LO    = 4'd4;
    localparam logic [3:0] S_HI    = 4'd5;
    localparam logic [3:0] S_ADD   = 4'd6;
    localparam logic [3:0] S_RND   = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam int CW = ucod_pkg::CNT_W;
    localparam int AW = ucod_pkg::MUL_A_W;

    // ---------------------------------------------------------------
    // Configuration registers; the port never stalls.
    // ---------------------------------------------------------------
    logic [ucod_pkg::MODE_W-1:0]  mode_reg;
    logic [ucod_pkg::LIMIT_W-1:0] limit_reg;
    logic [ucod_pkg::BIN_W-1:0]   bin_reg;
    logic                         cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ucod_pkg::MODE_ARGMAX;
            limit_reg <= ucod_pkg::LIMIT_RST;
            bin_reg   <= {{(ucod_pkg::BIN_W-1){1'b0}}, 1'b1};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ucod_pkg::REG_MODE:  mode_reg  <= cfg_data[ucod_pkg::MODE_W-1:0];
                ucod_pkg::REG_LIMIT: limit_reg <= cfg_data[ucod_pkg::LIMIT_W-1:0];
                ucod_pkg::REG_BIN:   bin_reg   <= cfg_data[ucod_pkg::BIN_W-1:0];
                default: ;
            endcase
        end
    end

    // bin width zero behaves like one
    logic [ucod_pkg::BIN_W-1:0] bin_eff;
    assign bin_eff = (bin_reg == '0) ? {{(ucod_pkg::BIN_W-1){1'b0}}, 1'b1} : bin_reg;

    // ---------------------------------------------------------------
    // Handshake and sequencer registers
    // ---------------------------------------------------------------
    logic [3:0] state_reg, state_next;
    logic       end_reg, end_next;
    logic       acc_pend_reg, acc_pend_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;
    logic       load_out;
    logic       is_mean;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == S_OUT) && out_free;
    assign is_mean  = (mode_reg == ucod_pkg::MODE_MEAN);

    // ---------------------------------------------------------------
    // Row tracker
    // ---------------------------------------------------------------
    ucod_pkg::row_ctl_t  row_ctl;
    ucod_pkg::row_stat_t row_stat;

    assign row_ctl = '{take: accept, clear: load_out};

    ucod_row_track #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_row_track (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (row_ctl),
        .score (score),
        .limit (limit_reg),
        .stat  (row_stat)
    );

    // ---------------------------------------------------------------
    // Final decode selection, evaluated in S_NL from the settled row status.
    // ---------------------------------------------------------------
    logic [CW-1:0]               n_minus1;
    logic [AW-1:0]               last_ext;
    logic [AW-1:0]               first_adj;
    logic [AW-1:0]               first_rnd;
    logic [AW-1:0]               sel_a;
    logic [ucod_pkg::BIN_W-1:0]  sel_b;
    logic                        sel_dead;
    logic [ucod_pkg::SCORE_W-1:0] sel_conf;

    assign n_minus1 = row_stat.count - 1'b1;
    assign last_ext = {row_stat.last[ucod_pkg::SCORE_W-1], row_stat.last};
    // round half away from zero: add 0.5 for positive, 0.5 - lsb for negative, then floor
    assign first_adj = {row_stat.first[ucod_pkg::SCORE_W-1], row_stat.first}
                     + (row_stat.first[ucod_pkg::SCORE_W-1] ? 33'd32767 : 33'd32768);
    assign first_rnd = $signed(first_adj) >>> 16;

    always_comb
    begin
        sel_a    = '0;
        sel_b    = bin_eff;
        sel_dead = 1'b0;
        sel_conf = ucod_pkg::NO_CONF;
        case (mode_reg)
            ucod_pkg::MODE_REGR:
            begin
                sel_a = first_rnd;
            end
            ucod_pkg::MODE_ARGMAX:
            begin
                sel_a    = {{(AW-ucod_pkg::POS_W){row_stat.arg_pos[ucod_pkg::POS_W-1]}},
                            row_stat.arg_pos};
                sel_conf = row_stat.arg_val;
            end
            ucod_pkg::MODE_UNARY:
            begin
                if (row_stat.hit)
                begin
                    sel_a    = {{(AW-ucod_pkg::POS_W){row_stat.hit_pos[ucod_pkg::POS_W-1]}},
                                row_stat.hit_pos};
                    sel_dead = (row_stat.hit_pos == '1);
                    sel_conf = ucod_pkg::sat_diff(row_stat.hit_conf);
                end
                else
                begin
                    // no digit fell below the limit: the whole row counts
                    sel_a = {{(AW-CW){1'b0}}, n_minus1};
                end
            end
            ucod_pkg::MODE_MAXCONF:
            begin
                // the closing digit against s[N] = 0 has confidence equal to the last score
                if ($signed(last_ext) > $signed(row_stat.best_val))
                begin
                    sel_a    = {{(AW-CW){1'b0}}, n_minus1};
                    sel_conf = row_stat.last;
                end
                else
                begin
                    sel_a    = {{(AW-ucod_pkg::POS_W){row_stat.best_pos[ucod_pkg::POS_W-1]}},
                                row_stat.best_pos};
                    sel_dead = (row_stat.best_pos == '1);
                    sel_conf = ucod_pkg::sat_diff(row_stat.best_val);
                end
            end
            ucod_pkg::MODE_MEAN:
            begin
                // closing term (N-1) * last of the weighted sum
                sel_a = last_ext;
                sel_b = {{(ucod_pkg::BIN_W-CW){1'b0}}, n_minus1};
            end
            default:
            begin
                sel_a = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Shared multiplier and its operand mux
    // ---------------------------------------------------------------
    logic [ucod_pkg::SUM_W-1:0]  wsum_reg, wsum_next;
    logic [AW-1:0]               mul_a;
    logic [ucod_pkg::BIN_W-1:0]  mul_b;
    logic                        mul_en;
    logic [ucod_pkg::PROD_W-1:0] prod;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        case (state_reg)
            S_MAC:
            begin
                // (i-1) * c term of the weighted sum; zero weight for element 0
                mul_a  = row_stat.mac_c;
                mul_b  = {{(ucod_pkg::BIN_W-CW){1'b0}}, row_stat.mac_k};
                mul_en = 1'b1;
            end
            S_NL:
            begin
                mul_a  = sel_a;
                mul_b  = sel_b;
                mul_en = 1'b1;
            end
            S_LO:
            begin
                mul_a  = {{(AW-24){1'b0}}, wsum_reg[23:0]};
                mul_b  = bin_eff;
                mul_en = 1'b1;
            end
            S_HI:
            begin
                mul_a  = {{(AW-24){wsum_reg[ucod_pkg::SUM_W-1]}},
                          wsum_reg[ucod_pkg::SUM_W-1:24]};
                mul_b  = bin_eff;
                mul_en = 1'b1;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    ucod_mult u_mult (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // ---------------------------------------------------------------
    // Weighted-sum accumulator: adds the registered product while acc_pend_reg is set.
    // ---------------------------------------------------------------
    always_comb
    begin
        wsum_next = wsum_reg;
        if (load_out)
            wsum_next = '0;
        else if (acc_pend_reg)
            wsum_next = wsum_reg + prod[ucod_pkg::SUM_W-1:0];
    end

    // ---------------------------------------------------------------
    // Scaling, rounding and result registers
    // ---------------------------------------------------------------
    logic [ucod_pkg::SCL_W-1:0]   scaled_reg, scaled_next;
    logic [ucod_pkg::SCL_W-1:0]   scaled_adj;
    logic                         dead_reg, dead_next;
    logic [ucod_pkg::SCORE_W-1:0] conf_reg, conf_next;
    logic [ucod_pkg::SCORE_W-1:0] heur_out_reg, heur_out_next;
    logic [ucod_pkg::SCORE_W-1:0] conf_out_reg, conf_out_next;

    assign scaled_adj = scaled_reg + (scaled_reg[ucod_pkg::SCL_W-1] ? 66'd32767 : 66'd32768);

    always_comb
    begin
        state_next     = state_reg;
        end_next       = end_reg;
        acc_pend_next  = 1'b0;
        out_valid_next = out_valid_reg;
        scaled_next    = scaled_reg;
        dead_next      = dead_reg;
        conf_next      = conf_reg;
        heur_out_next  = heur_out_reg;
        conf_out_next  = conf_out_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    end_next   = row_end;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                acc_pend_next = 1'b1;
                state_next    = end_reg ? S_NL : S_IDLE;
            end
            S_NL:
            begin
                dead_next     = sel_dead;
                conf_next     = sel_conf;
                acc_pend_next = is_mean;
                state_next    = is_mean ? S_WAIT : S_SCALE;
            end
            S_WAIT:
            begin
                state_next = S_LO;
            end
            S_LO:
            begin
                state_next = S_HI;
            end
            S_HI:
            begin
                // low partial product, non-negative
                scaled_next = {{(ucod_pkg::SCL_W-ucod_pkg::PROD_W){1'b0}}, prod};
                state_next  = S_ADD;
            end
            S_ADD:
            begin
                // high partial product carries weight 2^24
                scaled_next = scaled_reg + {prod[ucod_pkg::SCL_W-25:0], 24'd0};
                state_next  = S_RND;
            end
            S_RND:
            begin
                scaled_next = $signed(scaled_adj) >>> 16;
                state_next  = S_OUT;
            end
            S_SCALE:
            begin
                scaled_next = {{(ucod_pkg::SCL_W-ucod_pkg::PROD_W){prod[ucod_pkg::PROD_W-1]}},
                               prod};
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    heur_out_next  = dead_reg ? ucod_pkg::HEUR_DEAD
                                              : ucod_pkg::sat_wide(scaled_reg);
                    conf_out_next  = conf_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            end_reg       <= 1'b0;
            acc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wsum_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            end_reg       <= end_next;
            acc_pend_reg  <= acc_pend_next;
            out_valid_reg <= out_valid_next;
            wsum_reg      <= wsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg   <= scaled_next;
        dead_reg     <= dead_next;
        conf_reg     <= conf_next;
        heur_out_reg <= heur_out_next;
        conf_out_reg <= conf_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign heuristic  = heur_out_reg;
    assign confidence = conf_out_reg;

endmodule

// ----- hw/rtl/ucod_checker.sv -----
// Port-level assertion checker for the unary class output decoder, bound to the top level.
// Depends on unary_class_output_decoder_top_assert.svh and ucod_pkg.
`include "unary_class_output_decoder_top_assert.svh"

module ucod_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          row_end,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [ucod_pkg::SCORE_W-1:0]  heuristic,
    input logic [ucod_pkg::SCORE_W-1:0]  confidence
);

    // sequencer is busy right after any transfer
    `UCOD_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after transfer")
    // a mid-row element frees the input once its MAC pass is done
    `UCOD_ASSERT_IMP(a_mid_row_rate, clk, rst_n, in_valid && !in_stall && !row_end, (##2 !in_stall), "mid-row element not done in two cycles")
    // a row end keeps the input stalled past its MAC pass, into NL
    `UCOD_ASSERT_IMP(a_row_end_busy, clk, rst_n, in_valid && !in_stall && row_end, (##2 in_stall), "row end released input too early")
    // a stalled result stays put
    `UCOD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(heuristic) && $stable(confidence), "stalled result changed")

endmodule

bind unary_class_output_decoder_top ucod_checker u_ucod_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .row_end    (row_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .heuristic  (heuristic),
    .confidence (confidence)
);

// ----- tb/tb_unary_class_output_decoder_top.sv -----
// Self-checking testbench for unary_class_output_decoder_top: score rows in, decoded results out.
// Predicts every result in SystemVerilog and checks each output transfer field by field.
// Depends on ucod_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_unary_class_output_decoder_top;

    localparam int SCORE_W = ucod_pkg::SCORE_W;
    localparam int MODE_W  = ucod_pkg::MODE_W;
    localparam int LIMIT_W = ucod_pkg::LIMIT_W;
    localparam int BIN_W   = ucod_pkg::BIN_W;
    localparam int IDX_W   = ucod_pkg::IDX_W;
    localparam int DATA_W  = ucod_pkg::DATA_W;

    localparam int MAX_CLASSES  = 256;
    localparam int CYCLE_LIMIT  = 500000;  // many times the slowest legal run
    localparam int LATENCY_PAD  = 16;      // settling margin after the last expected result
    localparam int HOLD_CYCLES  = 200;     // long receiver hold-off
    localparam int PHASE_ITEMS  = 18;      // minimum items per configuration

    // Decode modes 5..7 have no meaning and must give the empty result.
    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [SCORE_W-1:0] heuristic;
        logic [SCORE_W-1:0] confidence;
    } decoded_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [SCORE_W-1:0] score;
    logic               row_end;
    logic               out_valid;
    logic               out_stall;
    logic [SCORE_W-1:0] heuristic;
    logic [SCORE_W-1:0] confidence;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]  cfg_data;

    unary_class_output_decoder_top #(
        .MAX_CLASSES(MAX_CLASSES)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .score      (score),
        .row_end    (row_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .heuristic  (heuristic),
        .confidence (confidence),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: mirror of the registers and of the running row state.
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]  mode_q;
    logic [LIMIT_W-1:0] limit_q;
    logic [BIN_W-1:0]   bin_q;

    int     elem_cnt;
    longint prev_s;       // previous element, 1.0 before the first
    longint first_s;      // element 0, for regression
    longint peak_s;       // argmax value
    longint peak_idx;     // argmax position
    longint gap_best;     // largest unary confidence so far
    longint gap_best_idx;
    bit     hit_flag;     // an element fell below the threshold
    longint hit_idx;
    longint hit_gap;
    longint wsum;         // running sum of (i-1)*c(i)

    decoded_t pending_decodes[$];  // expected results, oldest first

    int items_sent;
    int fail_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    logic hold_results;   // set while the receiver holds off on purpose

    function automatic void clear_row_state();
        elem_cnt     = 0;
        prev_s       = longint'(ucod_pkg::ONE_Q16);
        first_s      = 0;
        peak_s       = 0;
        peak_idx     = 0;
        gap_best     = 0;
        gap_best_idx = -1;
        hit_flag     = 1'b0;
        hit_idx      = 0;
        hit_gap      = 0;
        wsum         = 0;
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 to integer, half away from zero
    function automatic longint round_q16(input longint v);
        if (v >= 0)
            return (v + 32768) >>> 16;
        return -(((-v) + 32768) >>> 16);
    endfunction

    // Dead end passes through unscaled
    function automatic longint scale_bin(input longint h, input longint binv);
        if (h == -1)
            return -1;
        return sat32(h * binv);
    endfunction

    // Advance the row by one score; returns 1 with the result on row end.
    function automatic bit decode_score(input logic [SCORE_W-1:0] score_in,
                                        input logic last_in, output decoded_t res);
        longint s;
        longint c;
        longint i;
        longint n;
        longint binv;
        longint h;
        longint conf;
        s    = longint'($signed(score_in));
        binv = (bin_q == '0) ? 1 : longint'(bin_q);
        h    = 0;
        conf = longint'($signed(ucod_pkg::NO_CONF));
        res.heuristic  = '0;
        res.confidence = '0;
        if (elem_cnt < MAX_CLASSES)
        begin
            i = elem_cnt;
            c = prev_s - s;
            if (i == 0)
            begin
                first_s      = s;
                peak_s       = s;
                peak_idx     = 0;
                gap_best     = c;
                gap_best_idx = -1;
            end
            else
            begin
                if (s > peak_s)
                begin
                    peak_s   = s;
                    peak_idx = i;
                end
                if (c > gap_best)
                begin
                    gap_best     = c;
                    gap_best_idx = i - 1;
                end
                wsum = wsum + (i - 1) * c;
            end
            if (!hit_flag && s < longint'(limit_q))
            begin
                hit_flag = 1'b1;
                hit_idx  = i - 1;
                hit_gap  = c;
            end
            prev_s   = s;
            elem_cnt = elem_cnt + 1;
        end
        if (!last_in)
            return 1'b0;

        n = elem_cnt;
        case (mode_q)
            ucod_pkg::MODE_REGR:
                h = sat32(round_q16(first_s) * binv);
            ucod_pkg::MODE_ARGMAX:
            begin
                h    = scale_bin(peak_idx, binv);
                conf = peak_s;
            end
            ucod_pkg::MODE_UNARY:
            begin
                if (hit_flag)
                begin
                    h    = scale_bin(hit_idx, binv);
                    conf = sat32(hit_gap);
                end
                else
                    h = scale_bin(n - 1, binv);
            end
            ucod_pkg::MODE_MAXCONF:
            begin
                // s[N] = 0, so the last gap is the last element itself
                if (prev_s > gap_best)
                begin
                    gap_best     = prev_s;
                    gap_best_idx = n - 1;
                end
                h    = scale_bin(gap_best_idx, binv);
                conf = sat32(gap_best);
            end
            ucod_pkg::MODE_MEAN:
                h = sat32(round_q16((wsum + (n - 1) * prev_s) * binv));
            default:
                h = 0;
        endcase
        clear_row_state();
        res.heuristic  = h[SCORE_W-1:0];
        res.confidence = conf[SCORE_W-1:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall, forced stall during a hold-off, and the
    // field-by-field check of every accepted result.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_decodes.size() == 0)
            begin
                $error("result transfer with nothing pending: heuristic %h confidence %h",
                       heuristic, confidence);
                fail_count++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (heuristic !== want.heuristic)
                begin
                    $error("heuristic: expected %h actual %h", want.heuristic, heuristic);
                    fail_count++;
                end
                if (confidence !== want.confidence)
                begin
                    $error("confidence: expected %h actual %h", want.confidence, confidence);
                    fail_count++;
                end
            end
        end
        out_stall <= hold_results || ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_unary_class_output_decoder_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers. Every task starts and ends right after a rising edge.
    // ------------------------------------------------------------------

    // One score transfer, with a random idle gap in front of it.
    task automatic send_score(input logic [SCORE_W-1:0] value, input logic last);
        decoded_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        score    <= value;
        row_end  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (decode_score(value, last, res))
            pending_decodes.insert(pending_decodes.size(), res);
    endtask

    task automatic send_row(input logic [SCORE_W-1:0] vals[$]);
        for (int k = 0; k < vals.size(); k++)
            send_score(vals[k], k == vals.size() - 1);
    endtask

    // Wait for every expected result, then let any in-flight element settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ucod_pkg::REG_MODE:  mode_q  = data[MODE_W-1:0];
            ucod_pkg::REG_LIMIT: limit_q = data[LIMIT_W-1:0];
            ucod_pkg::REG_BIN:   bin_q   = data[BIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [MODE_W-1:0] mode, input logic [LIMIT_W-1:0] limit,
                                input logic [BIN_W-1:0] bin);
        drain_results();
        write_reg(ucod_pkg::REG_MODE,  DATA_W'(mode));
        write_reg(ucod_pkg::REG_LIMIT, DATA_W'(limit));
        write_reg(ucod_pkg::REG_BIN,   DATA_W'(bin));
        cfg_valid <= 1'b0;
    endtask

    // Short row; mostly a falling unary code, else raw or near-threshold noise.
    task automatic send_random_row();
        int len;
        int kind;
        longint v;
        logic [SCORE_W-1:0] word;
        len  = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
        kind = $urandom_range(99);
        v    = longint'($urandom_range(70000, 60000));
        for (int k = 0; k < len; k++)
        begin
            if (kind < 60)
            begin
                word = v[SCORE_W-1:0];
                v = v - longint'($urandom_range(30000));
                if ($urandom_range(7) == 0)
                    v = v + longint'($urandom_range(20000));
            end
            else if (kind < 85)
                word = $urandom();
            else
                word = {1'b0, limit_q} + $urandom_range(64) - 32;
            send_score(word, k == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every mode, dead end, saturation, zero bin, unused modes.
    task automatic test_directed_rows();
        // reset settings: argmax, threshold 0.5, bin 1
        send_row('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005});

        apply_config(ucod_pkg::MODE_REGR, ucod_pkg::LIMIT_RST, 16'd1);
        send_row('{32'h7FFF_8000});
        send_row('{32'hFFFF_8000});

        apply_config(ucod_pkg::MODE_UNARY, ucod_pkg::LIMIT_RST, 16'd1);
        send_row('{ucod_pkg::ONE_Q16, 32'd60000, 32'd40000, 32'd100, 32'd0});
        send_row('{32'd70000, ucod_pkg::ONE_Q16});     // never below the threshold
        send_row('{32'd0});                            // dead end

        // both gaps overflow 32 bits
        apply_config(ucod_pkg::MODE_MAXCONF, ucod_pkg::LIMIT_RST, 16'd5);
        send_row('{32'h8000_0000, 32'h7FFF_FFFF});

        // mean of -1.0 comes out as -1 without dead-end treatment
        apply_config(ucod_pkg::MODE_MEAN, ucod_pkg::LIMIT_RST, 16'd1);
        send_row('{32'd0, 32'hFFFF_0000});
        // large mean, largest bin, saturates
        apply_config(ucod_pkg::MODE_MEAN, 31'h7FFF_FFFF, 16'hFFFF);
        send_row('{ucod_pkg::ONE_Q16, ucod_pkg::ONE_Q16, 32'h7FFF_FFFF});

        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
        begin
            apply_config(MODE_W'(m), 31'd1, 16'd0);
            send_row('{32'h0001_2345});
        end

        // zero bin width behaves as one
        apply_config(ucod_pkg::MODE_ARGMAX, 31'd1, 16'd0);
        send_row('{32'd1, 32'd5});
    endtask

    // Mode and bin changed between elements of one row: row-end values rule.
    task automatic test_mid_row_update();
        apply_config(ucod_pkg::MODE_ARGMAX, ucod_pkg::LIMIT_RST, 16'd1);
        send_score(32'h0002_0000, 1'b0);
        send_score(32'h0003_0000, 1'b0);
        drain_results();
        write_reg(ucod_pkg::REG_MODE, DATA_W'(ucod_pkg::MODE_MAXCONF));
        write_reg(ucod_pkg::REG_BIN, DATA_W'(16'd7));
        cfg_valid <= 1'b0;
        send_score(ucod_pkg::ONE_Q16, 1'b1);
    endtask

    // Elements past MAX_CLASSES are dropped but their row end still counts.
    task automatic test_overlong_row();
        apply_config(ucod_pkg::MODE_MAXCONF, ucod_pkg::LIMIT_RST, 16'd3);
        for (int k = 0; k < MAX_CLASSES + 3; k++)
            send_score($urandom_range(131072), k == MAX_CLASSES + 2);
    endtask

    // Three idling phases, several settings each, extremes first.
    task automatic test_random_rows();
        int send_pct[3];
        int recv_pct[3];
        int start;
        logic [MODE_W-1:0]  mode;
        logic [LIMIT_W-1:0] limit;
        logic [BIN_W-1:0]   bin;
        send_pct = '{31, 71, 0};
        recv_pct = '{71, 31, 0};
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = send_pct[p];
            recv_idle_pct = recv_pct[p];
            for (int setting = 0; setting < 4; setting++)
            begin
                if (setting == 0)
                begin
                    mode  = (p == 2) ? ucod_pkg::MODE_MEAN : ucod_pkg::MODE_UNARY;
                    limit = (p == 0) ? 31'd1 : (p == 1) ? 31'h7FFF_FFFF : ucod_pkg::LIMIT_RST;
                    bin   = (p == 1) ? 16'd0 : 16'hFFFF;
                end
                else
                begin
                    mode = ($urandom_range(9) == 0) ? MODE_W'($urandom_range(7, 5))
                                                    : MODE_W'($urandom_range(4));
                    case ($urandom_range(3))
                        0:       limit = LIMIT_W'($urandom());
                        1:       limit = LIMIT_W'($urandom_range(65536, 1));
                        default: limit = ucod_pkg::LIMIT_RST;
                    endcase
                    case ($urandom_range(3))
                        0:       bin = BIN_W'($urandom());
                        1:       bin = BIN_W'($urandom_range(16, 1));
                        default: bin = 16'd1;
                    endcase
                    if (limit == '0)
                        limit = 31'd1;
                end
                apply_config(mode, limit, bin);
                start = items_sent;
                while (items_sent - start < PHASE_ITEMS)
                    send_random_row();
            end
        end
    endtask

    // Receiver holds off long enough for the block to back up into its input.
    task automatic test_input_backpressure();
        apply_config(ucod_pkg::MODE_MEAN, ucod_pkg::LIMIT_RST, 16'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_results <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results <= 1'b0;
            end
        join_none
        repeat (20) send_random_row();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        score         = '0;
        row_end       = 1'b0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = ucod_pkg::REG_MODE;
        cfg_data      = '0;
        hold_results  = 1'b0;
        items_sent    = 0;
        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        mode_q        = ucod_pkg::MODE_ARGMAX;
        limit_q       = ucod_pkg::LIMIT_RST;
        bin_q         = 16'd1;
        clear_row_state();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_rows();
        test_mid_row_update();
        test_overlong_row();
        test_random_rows();
        test_input_backpressure();
        drain_results();

        if (fail_count == 0)
            $display("tb_unary_class_output_decoder_top passed");
        else
            $display("tb_unary_class_output_decoder_top failed");
        $finish;
    end

endmodule
